// ----- src/tbma_pkg.sv -----
package tbma_pkg;

   // store geometry
   localparam int MEM_BYTES = 64;
   localparam int ADDR_W = 6;
   localparam int SIZE_W = 7;
   localparam logic [SIZE_W-1:0] MEM_BYTES_SIZE = SIZE_W'(MEM_BYTES);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // access mode
   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_SET = 1'b1;

   // data kinds
   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_SHORT = 2'd1;
   localparam logic [1:0] KIND_INT = 2'd2;
   localparam logic [1:0] KIND_STRING = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_NUM = 2'd0;
   localparam logic [1:0] STATUS_VIOL = 2'd1;
   localparam logic [1:0] STATUS_TEXT = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   // back-end operations
   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ_NUM = 2'd2;
   localparam logic [1:0] OP_READ_STR = 2'd3;

   // run length saturation point
   localparam logic [SIZE_W-1:0] RUN_LEN_MAX = '1;

   typedef struct packed {
      logic        mode;
      logic [1:0]  data_kind;
      logic [5:0]  address;
      logic [31:0] value;
      logic        last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] result_value;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [ADDR_W-1:0] addr;
      logic [2:0]        count;
      logic [31:0]       value;
      logic              viol;
      logic [SIZE_W-1:0] limit;
   } cmd_type;

endpackage

// ----- src/tbma_front.sv -----
module tbma_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       queue_full,
   input  tbma_pkg::req_type          req_payload,
   input  logic                       csr_write_enable,
   input  logic [tbma_pkg::SIZE_W-1:0] csr_write_data,
   output logic                       push,
   output tbma_pkg::cmd_type          push_cmd
);

   logic [tbma_pkg::SIZE_W-1:0] mem_size_ff;
   logic                        run_active_ff, run_active_in;
   logic [tbma_pkg::ADDR_W-1:0] run_start_ff, run_start_in;
   logic [tbma_pkg::SIZE_W-1:0] run_length_ff, run_length_in;
   logic                        run_rejected_ff, run_rejected_in;

   logic [tbma_pkg::SIZE_W-1:0] size;
   logic                        accept;
   logic                        addr_bad;
   logic [tbma_pkg::ADDR_W-1:0] eff_start;
   logic [tbma_pkg::SIZE_W-1:0] eff_len;
   logic                        eff_rej;
   logic [7:0]                  pos;
   logic [7:0]                  end_sum;
   logic [tbma_pkg::SIZE_W-1:0] new_len;
   logic                        str_write;
   logic                        str_bad;
   logic [2:0]                  width;
   logic                        over;
   logic [tbma_pkg::SIZE_W-1:0] room;
   logic                        need;

   // clamp the session size to the store
   assign size = (mem_size_ff > tbma_pkg::MEM_BYTES_SIZE) ? tbma_pkg::MEM_BYTES_SIZE
                                                          : mem_size_ff;
   assign accept = start && !queue_full;
   assign addr_bad = {1'b0, req_payload.address} >= size;

   // string-set run bookkeeping
   assign eff_start = run_active_ff ? run_start_ff : req_payload.address;
   assign eff_len = run_active_ff ? run_length_ff : '0;
   assign eff_rej = run_active_ff ? run_rejected_ff : addr_bad;
   assign pos = {2'b00, eff_start} + {1'b0, eff_len};
   assign new_len = (eff_len == tbma_pkg::RUN_LEN_MAX) ? eff_len : eff_len + 1'b1;
   assign end_sum = {2'b00, eff_start} + {1'b0, new_len};
   assign str_write = !eff_rej && (pos < {1'b0, size});
   assign str_bad = eff_rej || (end_sum >= {1'b0, size});

   // scalar width and fit
   always_comb begin
      case (req_payload.data_kind)
         tbma_pkg::KIND_CHAR:  width = 3'd1;
         tbma_pkg::KIND_SHORT: width = 3'd2;
         default:              width = 3'd4;
      endcase
   end
   assign over = ({1'b0, req_payload.address} + {4'b0000, width}) > size;
   assign room = size - {1'b0, req_payload.address};

   // classify the item into a back-end command
   always_comb begin
      run_active_in = 1'b0;
      run_start_in = '0;
      run_length_in = '0;
      run_rejected_in = 1'b0;
      need = 1'b0;
      push_cmd.op = tbma_pkg::OP_NONE;
      push_cmd.addr = req_payload.address;
      push_cmd.count = width;
      push_cmd.value = req_payload.value;
      push_cmd.viol = 1'b0;
      push_cmd.limit = size;
      if (req_payload.mode == tbma_pkg::MODE_SET &&
          req_payload.data_kind == tbma_pkg::KIND_STRING) begin
         if (!req_payload.last_byte) begin
            run_active_in = 1'b1;
            run_start_in = eff_start;
            run_length_in = new_len;
            run_rejected_in = eff_rej;
         end
         push_cmd.op = str_write ? tbma_pkg::OP_WRITE : tbma_pkg::OP_NONE;
         push_cmd.addr = pos[tbma_pkg::ADDR_W-1:0];
         push_cmd.count = 3'd1;
         push_cmd.viol = req_payload.last_byte && str_bad;
         need = str_write || push_cmd.viol;
      end else if (addr_bad) begin
         push_cmd.viol = 1'b1;
         need = 1'b1;
      end else if (req_payload.data_kind == tbma_pkg::KIND_STRING) begin
         push_cmd.op = tbma_pkg::OP_READ_STR;
         need = 1'b1;
      end else if (req_payload.mode == tbma_pkg::MODE_SET) begin
         push_cmd.op = tbma_pkg::OP_WRITE;
         push_cmd.count = over ? room[2:0] : width;
         push_cmd.viol = over;
         need = 1'b1;
      end else begin
         push_cmd.op = over ? tbma_pkg::OP_NONE : tbma_pkg::OP_READ_NUM;
         push_cmd.viol = over;
         need = 1'b1;
      end
   end

   assign push = accept && need;

   // hold session size and run state
   always_ff @(posedge clock) begin
      if (reset) begin
         mem_size_ff <= tbma_pkg::SIZE_W'(64);
         run_active_ff <= 1'b0;
         run_start_ff <= '0;
         run_length_ff <= '0;
         run_rejected_ff <= 1'b0;
      end else if (csr_write_enable) begin
         mem_size_ff <= csr_write_data;
         run_active_ff <= 1'b0;
         run_start_ff <= '0;
         run_length_ff <= '0;
         run_rejected_ff <= 1'b0;
      end else if (accept) begin
         run_active_ff <= run_active_in;
         run_start_ff <= run_start_in;
         run_length_ff <= run_length_in;
         run_rejected_ff <= run_rejected_in;
      end
   end

endmodule

// ----- src/tbma_queue.sv -----
module tbma_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tbma_pkg::cmd_type push_cmd,
   input  logic              pop,
   output tbma_pkg::cmd_type pop_cmd,
   output logic              empty,
   output logic              full
);

   tbma_pkg::cmd_type           entries_ff [tbma_pkg::QUEUE_DEPTH];
   logic [tbma_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [tbma_pkg::QCNT_W-1:0] count_ff;

   assign empty = (count_ff == '0);
   assign full = (count_ff == tbma_pkg::QCNT_W'(tbma_pkg::QUEUE_DEPTH));
   assign pop_cmd = entries_ff[rd_ptr_ff];

   // store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- src/tbma_back.sv -----
module tbma_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              queue_empty,
   input  tbma_pkg::cmd_type queue_cmd,
   output logic              pop,
   output logic              rsp_strobe,
   output tbma_pkg::rsp_type rsp_payload
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WRITE = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;

   logic [7:0]                   mem [tbma_pkg::MEM_BYTES];
   logic [tbma_pkg::MEM_BYTES-1:0] valid_ff;
   logic [7:0]                   rd_data_ff;
   logic                         rd_valid_ff;

   logic [1:0]                  state_ff, state_in;
   tbma_pkg::cmd_type           cur_ff, cur_in;
   logic [1:0]                  idx_ff, idx_in;
   logic [tbma_pkg::SIZE_W-1:0] ptr_ff, ptr_in;
   logic [tbma_pkg::SIZE_W-1:0] data_addr_ff, data_addr_in;
   logic [31:0]                 acc_ff, acc_in;
   logic                        pend_valid_ff, pend_valid_in;
   logic [7:0]                  pend_ff, pend_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   tbma_pkg::rsp_type           rsp_ff, rsp_in;

   logic [tbma_pkg::ADDR_W-1:0] rd_addr;
   logic                        wr_en;
   logic [tbma_pkg::ADDR_W-1:0] wr_addr;
   logic [7:0]                  wr_data;
   logic [7:0]                  rd_byte;
   logic                        idx_last;
   logic                        str_end;

   assign rd_byte = rd_valid_ff ? rd_data_ff : 8'h00;
   assign idx_last = ({1'b0, idx_ff} == (cur_ff.count - 3'd1));
   assign str_end = (data_addr_ff >= cur_ff.limit) || (rd_byte == 8'h00);
   assign wr_addr = cur_ff.addr + {{(tbma_pkg::ADDR_W-2){1'b0}}, idx_ff};
   assign wr_data = cur_ff.value[{idx_ff, 3'b000} +: 8];

   // sequence the command one byte per cycle
   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      idx_in = idx_ff;
      ptr_in = ptr_ff;
      data_addr_in = data_addr_ff;
      acc_in = acc_ff;
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      pop = 1'b0;
      wr_en = 1'b0;
      rd_addr = ptr_ff[tbma_pkg::ADDR_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               cur_in = queue_cmd;
               idx_in = '0;
               acc_in = '0;
               pend_valid_in = 1'b0;
               data_addr_in = {1'b0, queue_cmd.addr};
               ptr_in = {1'b0, queue_cmd.addr} + 1'b1;
               rd_addr = queue_cmd.addr;
               case (queue_cmd.op)
                  tbma_pkg::OP_WRITE: state_in = ST_WRITE;
                  tbma_pkg::OP_READ_NUM, tbma_pkg::OP_READ_STR: state_in = ST_READ;
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.status = tbma_pkg::STATUS_VIOL;
                     rsp_in.result_value = '0;
                     rsp_in.last = 1'b1;
                  end
               endcase
            end
         end
         ST_WRITE: begin
            wr_en = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_last) begin
               state_in = ST_IDLE;
               if (cur_ff.viol) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.status = tbma_pkg::STATUS_VIOL;
                  rsp_in.result_value = '0;
                  rsp_in.last = 1'b1;
               end
            end
         end
         ST_READ: begin
            if (cur_ff.op == tbma_pkg::OP_READ_NUM) begin
               acc_in[{idx_ff, 3'b000} +: 8] = rd_byte;
               idx_in = idx_ff + 1'b1;
               ptr_in = ptr_ff + 1'b1;
               if (idx_last) begin
                  state_in = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_in.status = tbma_pkg::STATUS_NUM;
                  rsp_in.result_value = acc_in;
                  rsp_in.last = 1'b1;
               end
            end else if (!str_end) begin
               // hold one byte back so the final one can carry last
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.status = tbma_pkg::STATUS_TEXT;
                  rsp_in.result_value = {24'h000000, pend_ff};
                  rsp_in.last = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_in = rd_byte;
               data_addr_in = ptr_ff;
               ptr_in = ptr_ff + 1'b1;
            end else begin
               state_in = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in.last = 1'b1;
               if (pend_valid_ff) begin
                  rsp_in.status = tbma_pkg::STATUS_TEXT;
                  rsp_in.result_value = {24'h000000, pend_ff};
               end else begin
                  rsp_in.status = tbma_pkg::STATUS_EMPTY;
                  rsp_in.result_value = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      ptr_ff <= ptr_in;
      data_addr_ff <= data_addr_in;
      acc_ff <= acc_in;
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
   end

   // byte store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // per-byte valid bits; unwritten bytes read as zero
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_IDLE))
      else $error("command taken while back end busy");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ({1'b0, wr_addr} < cur_ff.limit))
      else $error("store write past session size");

   a_clear_valid: assert property (@(posedge clock) disable iff (reset)
      clear |=> (valid_ff == '0))
      else $error("valid bits survive a session clear");

   a_num_from_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == tbma_pkg::STATUS_NUM) |->
         ($past(state_ff) == ST_READ))
      else $error("number result outside read sequence");

endmodule

// ----- src/typed_byte_memory_access.sv -----
// Channel     Ports                                   Handshake
// request     start, busy, req_payload                transfer when start && !busy
// result      rsp_strobe, rsp_payload                 a strobe per result, no stall
// config      csr_write_enable, csr_write_data        write on enable, no wait
//
// While the queue is not full, the front classifies one request per cycle into a
// byte command; a four-entry command queue feeds the back end, which touches the
// byte store once a cycle. A set writes its bytes, a number get packs them into
// one result, a string get sends its text; busy rises only when the queue fills.
// Reset is synchronous; reset and a config write clear the store at once.
// Results leave on a strobe; the receiver cannot hold them off.
module typed_byte_memory_access (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  tbma_pkg::req_type           req_payload,
   output logic                        rsp_strobe,
   output tbma_pkg::rsp_type           rsp_payload,
   input  logic                        csr_write_enable,
   input  logic [tbma_pkg::SIZE_W-1:0] csr_write_data
);

   logic              push;
   logic              pop;
   logic              queue_empty;
   logic              queue_full;
   tbma_pkg::cmd_type push_cmd;
   tbma_pkg::cmd_type pop_cmd;

   assign busy = queue_full;

   tbma_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .queue_full       (queue_full),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   tbma_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   tbma_back u_back (
      .clock       (clock),
      .reset       (reset),
      .clear       (csr_write_enable),
      .queue_empty (queue_empty),
      .queue_cmd   (pop_cmd),
      .pop         (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned TAIL_CYCLES = 100;
   localparam int unsigned DRAIN_LIMIT = 20000;
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned MAX_PRINTS = 20;

   // one planned transfer: either a size write or an access
   typedef struct {
      bit                          is_size;
      logic [tbma_pkg::SIZE_W-1:0] size_val;
      tbma_pkg::req_type           acc;
      int unsigned                 idle;
   } plan_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   tbma_pkg::req_type req_payload = '0;
   logic rsp_strobe;
   tbma_pkg::rsp_type rsp_payload;
   logic csr_write_enable = 1'b0;
   logic [tbma_pkg::SIZE_W-1:0] csr_write_data = '0;

   plan_item_type access_plan[$];
   tbma_pkg::rsp_type access_results[$];

   // mirror of the byte store and string-set run
   logic [7:0] mem_image [tbma_pkg::MEM_BYTES];
   logic [tbma_pkg::SIZE_W-1:0] mem_limit = tbma_pkg::MEM_BYTES_SIZE;
   bit str_open = 1'b0;
   int unsigned str_base = 0;
   int unsigned str_count = 0;
   bit str_bad = 1'b0;

   int unsigned idle_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned accepted_count = 0;
   int unsigned result_count = 0;
   int unsigned size_changes = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit burst_mode = 1'b0;

   typed_byte_memory_access dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_payload      (req_payload),
      .rsp_strobe       (rsp_strobe),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
   endtask

   function automatic void post_result(input logic [1:0] st, input logic [31:0] v,
                                       input logic l);
      tbma_pkg::rsp_type o;
      o.status = st;
      o.result_value = v;
      o.last = l;
      access_results.push_back(o);
   endfunction

   // new session: clear the store and drop any open run
   function automatic void apply_size(input logic [tbma_pkg::SIZE_W-1:0] v);
      mem_limit = v;
      for (int i = 0; i < tbma_pkg::MEM_BYTES; i++) mem_image[i] = 8'h00;
      str_open = 1'b0;
      str_base = 0;
      str_count = 0;
      str_bad = 1'b0;
   endfunction

   // predict the results of one accepted access and update the mirror
   function automatic void apply_access(input tbma_pkg::req_type r);
      int unsigned lim, pos, w, p, a;
      logic [31:0] word;
      bit over, fin;
      lim = (mem_limit > tbma_pkg::MEM_BYTES) ? tbma_pkg::MEM_BYTES : mem_limit;
      a = r.address;
      if (r.mode == tbma_pkg::MODE_SET && r.data_kind == tbma_pkg::KIND_STRING) begin
         if (!str_open) begin
            str_open = 1'b1;
            str_base = a;
            str_count = 0;
            str_bad = (a >= lim);
         end
         pos = str_base + str_count;
         if (!str_bad && pos < lim) mem_image[pos] = r.value[7:0];
         if (str_count < tbma_pkg::RUN_LEN_MAX) str_count++;
         if (r.last_byte) begin
            over = str_bad || (str_base + str_count >= lim);
            str_open = 1'b0;
            str_base = 0;
            str_count = 0;
            str_bad = 1'b0;
            if (over) post_result(tbma_pkg::STATUS_VIOL, 32'd0, 1'b1);
         end
         return;
      end
      // any other access ends an open run silently
      str_open = 1'b0;
      str_base = 0;
      str_count = 0;
      str_bad = 1'b0;
      if (a >= lim) begin
         post_result(tbma_pkg::STATUS_VIOL, 32'd0, 1'b1);
         return;
      end
      if (r.data_kind == tbma_pkg::KIND_STRING) begin
         p = a;
         if (mem_image[p] == 8'h00) begin
            post_result(tbma_pkg::STATUS_EMPTY, 32'd0, 1'b1);
            return;
         end
         while (p < lim && mem_image[p] != 8'h00) begin
            fin = (p + 1 >= lim) ? 1'b1 : (mem_image[p + 1] == 8'h00);
            post_result(tbma_pkg::STATUS_TEXT, {24'd0, mem_image[p]}, fin);
            p++;
         end
         return;
      end
      w = (r.data_kind == tbma_pkg::KIND_CHAR) ? 1 :
          ((r.data_kind == tbma_pkg::KIND_SHORT) ? 2 : 4);
      over = (a + w > lim);
      if (r.mode == tbma_pkg::MODE_SET) begin
         for (int unsigned i = 0; i < w; i++)
            if (a + i < lim) mem_image[a + i] = r.value[8*i +: 8];
         if (over) post_result(tbma_pkg::STATUS_VIOL, 32'd0, 1'b1);
         return;
      end
      if (over) begin
         post_result(tbma_pkg::STATUS_VIOL, 32'd0, 1'b1);
         return;
      end
      word = '0;
      for (int unsigned i = 0; i < w; i++) word[8*i +: 8] = mem_image[a + i];
      post_result(tbma_pkg::STATUS_NUM, word, 1'b1);
   endfunction

   // mostly short gaps, a few long ones, none inside a burst
   function automatic int unsigned pick_idle();
      int unsigned r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic void add_access(input logic m, input logic [1:0] k,
                                      input logic [5:0] ad, input logic [31:0] v,
                                      input logic lb);
      plan_item_type it;
      it.is_size = 1'b0;
      it.size_val = '0;
      it.acc.mode = m;
      it.acc.data_kind = k;
      it.acc.address = ad;
      it.acc.value = v;
      it.acc.last_byte = lb;
      it.idle = pick_idle();
      access_plan.push_back(it);
   endfunction

   function automatic void add_size(input logic [tbma_pkg::SIZE_W-1:0] v);
      plan_item_type it;
      it.is_size = 1'b1;
      it.size_val = v;
      it.acc = '0;
      it.idle = 0;
      access_plan.push_back(it);
   endfunction

   function automatic logic [5:0] pick_addr(input int unsigned lim);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (lim == 0 || r == 9) return 6'($urandom_range(0, 63));
      if (r == 8) return 6'((lim > 4) ? $urandom_range(lim - 4, lim - 1) : $urandom_range(0, lim - 1));
      return 6'($urandom_range(0, lim - 1));
   endfunction

   function automatic logic [7:0] pick_text();
      if ($urandom_range(0, 19) == 0) return 8'h00;
      return 8'($urandom_range(1, 255));
   endfunction

   // well-formed traffic with random content, plus some noise
   function automatic void add_random_traffic(input int unsigned lim, input int unsigned count);
      int unsigned made, n, sel;
      logic [5:0] base;
      bit cut;
      made = 0;
      while (made < count) begin
         if (made % 10 == 0) burst_mode = ($urandom_range(0, 2) == 0);
         sel = $urandom_range(0, 9);
         if (sel <= 2) begin
            add_access(tbma_pkg::MODE_SET, 2'($urandom_range(0, 2)), pick_addr(lim),
                       $urandom(), 1'b1);
            made++;
         end else if (sel <= 5) begin
            add_access(tbma_pkg::MODE_GET, 2'($urandom_range(0, 2)), pick_addr(lim),
                       $urandom(), 1'b1);
            made++;
         end else if (sel <= 7) begin
            n = $urandom_range(1, 6);
            base = pick_addr(lim);
            cut = ($urandom_range(0, 6) == 0);
            for (int unsigned i = 0; i < n; i++)
               add_access(tbma_pkg::MODE_SET, tbma_pkg::KIND_STRING,
                          (i == 0) ? base : 6'($urandom_range(0, 63)),
                          {24'($urandom()), pick_text()}, (i == n - 1) && !cut);
            made += n;
            if ($urandom_range(0, 9) < 7) begin
               add_access(tbma_pkg::MODE_GET, tbma_pkg::KIND_STRING, base, $urandom(),
                          1'($urandom_range(0, 1)));
               made++;
            end
         end else if (sel == 8) begin
            add_access(tbma_pkg::MODE_GET, tbma_pkg::KIND_STRING, pick_addr(lim),
                       $urandom(), 1'b1);
            made++;
         end else begin
            add_access(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                       6'($urandom_range(0, 63)), $urandom(), 1'($urandom_range(0, 1)));
            made++;
         end
      end
      burst_mode = 1'b0;
   endfunction

   // driver: present planned transfers, write the size only when idle
   always @(posedge clock) begin : driver
      logic start_nx;
      logic we_nx;
      plan_item_type head;
      start_nx = start;
      we_nx = 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            apply_access(req_payload);
            accepted_count++;
            start_nx = 1'b0;
         end
         if (!start_nx) begin
            if (idle_left != 0) begin
               idle_left--;
            end else if (access_plan.size() != 0) begin
               head = access_plan[0];
               if (head.is_size) begin
                  if (access_results.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                     head = access_plan.pop_front();
                     we_nx = 1'b1;
                     csr_write_data <= head.size_val;
                     apply_size(head.size_val);
                     size_changes++;
                     idle_left = 2;
                  end
               end else begin
                  head = access_plan.pop_front();
                  req_payload <= head.acc;
                  start_nx = 1'b1;
                  idle_left = head.idle;
               end
            end
         end
         quiet_cycles = (access_results.size() == 0 && !start_nx) ? quiet_cycles + 1 : 0;
      end
      start <= start_nx;
      csr_write_enable <= we_nx;
   end

   // monitor: compare each result transfer with the oldest prediction
   always @(posedge clock) begin : monitor
      tbma_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         result_count++;
         if (access_results.size() == 0) begin
            report_mismatch("unexpected result, value", rsp_payload.result_value, 32'd0);
         end else begin
            want = access_results.pop_front();
            if (rsp_payload.status !== want.status)
               report_mismatch("status", 32'(rsp_payload.status), 32'(want.status));
            if (rsp_payload.result_value !== want.result_value)
               report_mismatch("result_value", rsp_payload.result_value, want.result_value);
            if (rsp_payload.last !== want.last)
               report_mismatch("last", 32'(rsp_payload.last), 32'(want.last));
         end
      end
   end

   // hard stop
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned waited;
      int unsigned lim;
      logic [tbma_pkg::SIZE_W-1:0] sizes [8];
      for (int i = 0; i < tbma_pkg::MEM_BYTES; i++) mem_image[i] = 8'h00;

      // directed: full store after reset
      add_access(tbma_pkg::MODE_SET, tbma_pkg::KIND_INT, 6'd0, 32'hFFFF_FFFF, 1'b1);
      add_access(tbma_pkg::MODE_GET, tbma_pkg::KIND_INT, 6'd0, 32'h0000_0000, 1'b0);
      add_access(tbma_pkg::MODE_SET, tbma_pkg::KIND_SHORT, 6'd4, 32'h1234_5678, 1'b1);
      add_access(tbma_pkg::MODE_GET, tbma_pkg::KIND_SHORT, 6'd4, 32'h0, 1'b1);
      add_access(tbma_pkg::MODE_GET, tbma_pkg::KIND_INT, 6'd4, 32'h0, 1'b1);
      add_access(tbma_pkg::MODE_SET, tbma_pkg::KIND_CHAR, 6'd63, 32'h0000_00A5, 1'b1);
      add_access(tbma_pkg::MODE_GET, tbma_pkg::KIND_CHAR, 6'd63, 32'h0, 1'b1);
      add_access(tbma_pkg::MODE_GET, tbma_pkg::KIND_INT, 6'd62, 32'h0, 1'b1);
      add_access(tbma_pkg::MODE_SET, tbma_pkg::KIND_SHORT, 6'd63, 32'h0000_BEEF, 1'b1);
      add_access(tbma_pkg::MODE_GET, tbma_pkg::KIND_CHAR, 6'd63, 32'h0, 1'b1);
      add_access(tbma_pkg::MODE_SET, tbma_pkg::KIND_STRING, 6'd10, 32'h48, 1'b0);
      add_access(tbma_pkg::MODE_SET, tbma_pkg::KIND_STRING, 6'd33, 32'h69, 1'b1);
      add_access(tbma_pkg::MODE_GET, tbma_pkg::KIND_STRING, 6'd10, 32'h0, 1'b1);
      add_access(tbma_pkg::MODE_GET, tbma_pkg::KIND_STRING, 6'd20, 32'h0, 1'b1);
      // string set running off the end
      add_access(tbma_pkg::MODE_SET, tbma_pkg::KIND_STRING, 6'd62, 32'h61, 1'b0);
      add_access(tbma_pkg::MODE_SET, tbma_pkg::KIND_STRING, 6'd0, 32'h62, 1'b0);
      add_access(tbma_pkg::MODE_SET, tbma_pkg::KIND_STRING, 6'd0, 32'h63, 1'b1);
      add_access(tbma_pkg::MODE_GET, tbma_pkg::KIND_STRING, 6'd62, 32'h0, 1'b1);
      // interrupted run, then the written byte reads back
      add_access(tbma_pkg::MODE_SET, tbma_pkg::KIND_STRING, 6'd30, 32'hFFFF_FF78, 1'b0);
      add_access(tbma_pkg::MODE_GET, tbma_pkg::KIND_CHAR, 6'd30, 32'h0, 1'b1);
      add_access(tbma_pkg::MODE_GET, tbma_pkg::KIND_STRING, 6'd0, 32'h0, 1'b1);
      // zero size: everything is a violation
      add_size(7'd0);
      add_access(tbma_pkg::MODE_GET, tbma_pkg::KIND_CHAR, 6'd0, 32'h0, 1'b1);
      add_access(tbma_pkg::MODE_SET, tbma_pkg::KIND_INT, 6'd0, 32'hFFFF_FFFF, 1'b1);
      add_access(tbma_pkg::MODE_SET, tbma_pkg::KIND_STRING, 6'd0, 32'h41, 1'b1);
      // oversize acts as full store
      add_size(7'd127);
      add_access(tbma_pkg::MODE_SET, tbma_pkg::KIND_INT, 6'd60, 32'hCAFE_F00D, 1'b1);
      add_access(tbma_pkg::MODE_GET, tbma_pkg::KIND_INT, 6'd60, 32'h0, 1'b1);

      // one long run that crosses the end of the store
      add_size(tbma_pkg::MEM_BYTES_SIZE);
      for (int unsigned i = 0; i < 36; i++)
         add_access(tbma_pkg::MODE_SET, tbma_pkg::KIND_STRING,
                    (i == 0) ? 6'd40 : 6'($urandom_range(0, 63)),
                    {24'($urandom()), 8'($urandom_range(1, 255))}, i == 35);
      add_access(tbma_pkg::MODE_GET, tbma_pkg::KIND_STRING, 6'd40, 32'h0, 1'b1);

      // random phases over several store sizes
      sizes[0] = tbma_pkg::MEM_BYTES_SIZE;
      sizes[1] = 7'($urandom_range(5, 63));
      sizes[2] = 7'd127;
      sizes[3] = 7'd4;
      sizes[4] = 7'd1;
      sizes[5] = 7'd0;
      sizes[6] = 7'($urandom_range(65, 126));
      sizes[7] = 7'($urandom_range(1, 64));
      for (int i = 0; i < 8; i++) begin
         add_size(sizes[i]);
         lim = (sizes[i] > tbma_pkg::MEM_BYTES) ? tbma_pkg::MEM_BYTES : sizes[i];
         add_random_traffic(lim, 8);
      end

      // hold reset, then release
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (access_plan.size() != 0 || start) @(posedge clock);
      waited = 0;
      while (access_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (access_results.size() != 0)
         report_mismatch("results never arrived, count", 32'd0, 32'(access_results.size()));

      $display("covered %0d accesses and %0d results across %0d store size writes",
               accepted_count, result_count, size_changes);
      $display("mismatches counted: %0d", error_count);
      if (error_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/tbma_pkg.sv
src/tbma_front.sv
src/tbma_queue.sv
src/tbma_back.sv
src/typed_byte_memory_access.sv
sim/tb_top.sv
